// ----- rtl/core/rnf_pkg.sv -----
// Package for the radix number formatter: widths, character codes, FSM and command types.
`default_nettype none
package rnf_pkg;

    // Payload field widths
    localparam int VALUE_W = 16;
    localparam int RADIX_W = 6;
    localparam int PAD_W   = 7;
    localparam int CHAR_W  = 7;

    // Conversion sizing
    localparam int VALUE_BITS = 16;
    localparam int MAX_DIGITS = 16;
    localparam int PAD_MAX    = 63;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W     = $clog2(MAX_DIGITS);
    localparam int MAG_W     = $clog2(PAD_MAX + 1);

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CH_A     = CHAR_W'(65);
    localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(32);
    localparam logic [RADIX_W-1:0] TEN     = RADIX_W'(10);

    // Controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_STORE  = 6'b000100,
        S_SETPAD = 6'b001000,
        S_PAD    = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic set_pad;
        logic emit_pad;
        logic emit_digit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic more;
        logic pad_zero;
        logic last_digit;
        logic out_free;
    } t_dp_status;

    // Digit value to ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < TEN) begin
            digit_char = CH_ZERO + dx;
        end else begin
            digit_char = CH_A + dx - CHAR_W'(TEN);
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rnf_in_if.sv -----
// Request channel carrying one number to format.
`default_nettype none
interface rnf_in_if;
    logic                          valid;
    logic                          ready;
    logic [rnf_pkg::VALUE_W-1:0]   value;
    logic [rnf_pkg::RADIX_W-1:0]   radix;
    logic signed [rnf_pkg::PAD_W-1:0] pad_width;

    modport source(output valid, output value, output radix, output pad_width, input ready);
    modport sink(input valid, input value, input radix, input pad_width, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rnf_out_if.sv -----
// Character channel carrying one formatted character per transfer.
`default_nettype none
interface rnf_out_if;
    logic                        valid;
    logic                        ready;
    logic [rnf_pkg::CHAR_W-1:0]  char_code;
    logic                        last_char;

    modport source(output valid, output char_code, output last_char, input ready);
    modport sink(input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rnf_ctrl.sv -----
// Controller FSM sequencing division, digit store, padding and character output.
`default_nettype none
module rnf_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire rnf_pkg::t_dp_status i_status,
    output rnf_pkg::t_dp_cmd         o_cmd,
    output logic                     o_idle
);

    rnf_pkg::t_state r_state;
    rnf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rnf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            rnf_pkg::S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = rnf_pkg::S_DIV;
                end
            end
            rnf_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = rnf_pkg::S_STORE;
                end
            end
            rnf_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
                n_state = i_status.more ? rnf_pkg::S_DIV : rnf_pkg::S_SETPAD;
            end
            rnf_pkg::S_SETPAD: begin
                o_cmd.set_pad = 1'b1;
                n_state = rnf_pkg::S_PAD;
            end
            rnf_pkg::S_PAD: begin
                if (i_status.pad_zero) begin
                    n_state = rnf_pkg::S_EMIT;
                end else if (i_status.out_free) begin
                    o_cmd.emit_pad = 1'b1;
                end
            end
            rnf_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.last_digit) begin
                        n_state = rnf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rnf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == rnf_pkg::S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/core/rnf_dp.sv -----
// Datapath: bit-serial divider, digit store, pad counter and output register.
`default_nettype none
module rnf_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rnf_pkg::t_dp_cmd              i_cmd,
    output rnf_pkg::t_dp_status                o_status,
    input  wire logic [rnf_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [rnf_pkg::RADIX_W-1:0]   i_radix,
    input  wire logic [rnf_pkg::PAD_W-1:0]     i_pad_width,
    rnf_out_if.source                          o_chr
);

    localparam int VB = rnf_pkg::VALUE_BITS;

    logic [VB-1:0]                    r_quot;
    logic [rnf_pkg::RADIX_W-1:0]      r_rem;
    logic [rnf_pkg::RADIX_W-1:0]      r_radix;
    logic [rnf_pkg::BIT_CNT_W-1:0]    r_bit_cnt;
    logic [rnf_pkg::CNT_W-1:0]        r_digit_cnt;
    logic [rnf_pkg::MAG_W-1:0]        r_mag;
    logic [rnf_pkg::CHAR_W-1:0]       r_pad_ch;
    logic [rnf_pkg::PAD_W-1:0]        r_pad_rem;
    logic [rnf_pkg::CHAR_W-1:0]       r_store [rnf_pkg::MAX_DIGITS];
    logic                             r_out_valid;
    logic [rnf_pkg::CHAR_W-1:0]       r_out_char;
    logic                             r_out_last;

    logic [rnf_pkg::RADIX_W:0]        rem_sh;
    logic                             rem_ge;
    logic [rnf_pkg::RADIX_W-1:0]      radix_clamped;
    logic [rnf_pkg::PAD_W-1:0]        pad_neg;
    logic [rnf_pkg::PAD_W-1:0]        pad_abs;
    logic [rnf_pkg::MAG_W-1:0]        mag_sat;
    logic [rnf_pkg::CHAR_W-1:0]       pad_ch_sel;
    logic [rnf_pkg::CNT_W:0]          cnt_inc;
    logic [rnf_pkg::PAD_W-1:0]        mag_x;
    logic [rnf_pkg::PAD_W-1:0]        cnt_x;
    logic [rnf_pkg::CNT_W-1:0]        rd_cnt;
    logic                             out_free;

    // Input conditioning: radix clamp and pad magnitude/character
    always_comb begin
        if (i_radix < rnf_pkg::RADIX_MIN) begin
            radix_clamped = rnf_pkg::RADIX_MIN;
        end else if (i_radix > rnf_pkg::RADIX_MAX) begin
            radix_clamped = rnf_pkg::RADIX_MAX;
        end else begin
            radix_clamped = i_radix;
        end
        pad_neg    = rnf_pkg::PAD_W'(0) - i_pad_width;
        pad_abs    = i_pad_width[rnf_pkg::PAD_W-1] ? pad_neg : i_pad_width;
        pad_ch_sel = i_pad_width[rnf_pkg::PAD_W-1] ? rnf_pkg::CH_ZERO : rnf_pkg::CH_SPACE;
        if (pad_abs > rnf_pkg::PAD_W'(rnf_pkg::PAD_MAX)) begin
            mag_sat = rnf_pkg::MAG_W'(rnf_pkg::PAD_MAX);
        end else begin
            mag_sat = pad_abs[rnf_pkg::MAG_W-1:0];
        end
    end

    // One restoring division step
    assign rem_sh = {r_rem, r_quot[VB-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_radix});

    assign cnt_inc = {1'b0, r_digit_cnt} + (rnf_pkg::CNT_W+1)'(1);
    assign mag_x   = rnf_pkg::PAD_W'(r_mag);
    assign cnt_x   = rnf_pkg::PAD_W'(r_digit_cnt);
    assign rd_cnt  = r_digit_cnt - rnf_pkg::CNT_W'(1);
    assign out_free = !r_out_valid || o_chr.ready;

    // Conversion and pad registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_cnt <= '0;
            r_pad_rem   <= '0;
            r_bit_cnt   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_quot      <= i_value[VB-1:0];
                r_rem       <= '0;
                r_radix     <= radix_clamped;
                r_bit_cnt   <= rnf_pkg::BIT_CNT_W'(VB - 1);
                r_digit_cnt <= '0;
                r_mag       <= mag_sat;
                r_pad_ch    <= pad_ch_sel;
            end
            if (i_cmd.div_step) begin
                r_quot    <= {r_quot[VB-2:0], rem_ge};
                r_rem     <= rem_ge ? rnf_pkg::RADIX_W'(rem_sh - {1'b0, r_radix})
                                    : rem_sh[rnf_pkg::RADIX_W-1:0];
                r_bit_cnt <= r_bit_cnt - rnf_pkg::BIT_CNT_W'(1);
            end
            if (i_cmd.store) begin
                r_store[r_digit_cnt[rnf_pkg::IDX_W-1:0]] <= rnf_pkg::digit_char(r_rem);
                r_digit_cnt <= cnt_inc[rnf_pkg::CNT_W-1:0];
                r_rem       <= '0;
                r_bit_cnt   <= rnf_pkg::BIT_CNT_W'(VB - 1);
            end
            if (i_cmd.set_pad) begin
                r_pad_rem <= (mag_x >= cnt_x) ? (mag_x - cnt_x + rnf_pkg::PAD_W'(1)) : '0;
            end
            if (i_cmd.emit_pad) begin
                r_pad_rem <= r_pad_rem - rnf_pkg::PAD_W'(1);
            end
            if (i_cmd.emit_digit) begin
                r_digit_cnt <= rd_cnt;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pad || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (o_chr.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pad) begin
            r_out_char <= r_pad_ch;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= r_store[rd_cnt[rnf_pkg::IDX_W-1:0]];
            r_out_last <= (r_digit_cnt == rnf_pkg::CNT_W'(1));
        end
    end

    assign o_chr.valid     = r_out_valid;
    assign o_chr.char_code = r_out_char;
    assign o_chr.last_char = r_out_last;

    // Status to controller
    always_comb begin
        o_status.div_last   = (r_bit_cnt == '0);
        o_status.more       = (r_quot != '0) &&
                              (cnt_inc < (rnf_pkg::CNT_W+1)'(rnf_pkg::MAX_DIGITS));
        o_status.pad_zero   = (r_pad_rem == '0);
        o_status.last_digit = (r_digit_cnt == rnf_pkg::CNT_W'(1));
        o_status.out_free   = out_free;
    end

endmodule
`default_nettype wire

// ----- rtl/core/radix_number_formatter_top.sv -----
// Top level of the radix number formatter: controller plus datapath.
//
//  channel  | dir | payload                         | handshake
//  i_num    | in  | value, radix, pad_width         | valid/ready
//  o_chr    | out | char_code, last_char            | valid/ready
//
// One request is taken at a time; i_num.ready is high only while idle.
// Each digit is worked out in the bit-serial divider and stored; then the
// padding is sized, the pad characters are sent, padding is left, and the
// stored digits go out, most significant first.
// Output back-pressure stalls character emission only; the output register
// keeps the last character while the next request is being accepted.
// Reset is synchronous, active low, and returns the controller to idle.
`default_nettype none
module radix_number_formatter_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rnf_in_if.sink      i_num,
    rnf_out_if.source   o_chr
);

    rnf_pkg::t_dp_cmd    cmd;
    rnf_pkg::t_dp_status status;
    logic                idle;
    logic                accept;

    // Request handshake
    assign i_num.ready = idle;
    assign accept      = i_num.valid && idle;

    rnf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_status (status),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    rnf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (i_num.value),
        .i_radix     (i_num.radix),
        .i_pad_width (i_num.pad_width),
        .o_chr       (o_chr)
    );

endmodule
`default_nettype wire

// ----- test/radix_number_formatter_top_tb.sv -----
// Testbench for radix_number_formatter_top: directed table plus random numbers, checked per character.
module radix_number_formatter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run sizing
    localparam int N_DIRECTED    = 24;
    localparam int N_RANDOM      = 286;
    localparam int LONG_GAP_MIN  = 20;
    localparam int LONG_GAP_MAX  = 60;
    localparam int MAX_CHARS     = rnf_pkg::PAD_MAX + 1;
    localparam int DRAIN_CYCLES  = 400;
    // worst item: full bit-serial conversion, every char behind a long stall, a long send gap
    localparam int WORST_ITEM_CYCLES = rnf_pkg::MAX_DIGITS * (rnf_pkg::VALUE_BITS + 1) + 4
                                     + MAX_CHARS * (1 + LONG_GAP_MAX) + LONG_GAP_MAX;
    localparam int CYCLE_LIMIT = 4 * (N_DIRECTED + N_RANDOM) * WORST_ITEM_CYCLES + 1000;

    typedef struct packed {
        logic [rnf_pkg::VALUE_W-1:0]      value;
        logic [rnf_pkg::RADIX_W-1:0]      radix;
        logic signed [rnf_pkg::PAD_W-1:0] pad;
    } t_number_req;

    typedef struct packed {
        logic [rnf_pkg::CHAR_W-1:0] code;
        logic                       last;
    } t_char_exp;

    logic i_clk;
    logic i_rst_n;

    rnf_in_if  num_if ();
    rnf_out_if chr_if ();

    radix_number_formatter_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_if),
        .o_chr   (chr_if)
    );

    // Characters still owed by the block, oldest first
    t_char_exp pending_chars [$];
    t_char_exp head_char;
    int        bad_chars;
    int        cycle_count;
    int        rx_hold;
    bit        rx_stalls_on;
    bit        tx_gaps_on;

    // Directed requests; text is the literal output, empty where the predictor decides
    t_number_req dir_reqs [N_DIRECTED] = '{
        '{16'd0,     6'd10, 7'sd0},
        '{16'd65535, 6'd16, 7'sd0},
        '{16'd65535, 6'd2,  7'sd0},
        '{16'd65535, 6'd36, 7'sd0},
        '{16'd35,    6'd36, 7'sd0},
        '{16'd9,     6'd10, 7'sd0},
        '{16'd10,    6'd16, 7'sd0},
        '{16'd12345, 6'd10, 7'sd0},
        '{16'd7,     6'd10, 7'sd4},
        '{16'd7,     6'd10, -7'sd4},
        '{16'd7,     6'd10, 7'sd1},
        '{16'd42,    6'd10, -7'sd1},
        '{16'd42,    6'd10, 7'sd2},
        '{16'd255,   6'd16, -7'sd3},
        '{16'd5,     6'd0,  7'sd0},
        '{16'd6,     6'd1,  7'sd0},
        '{16'd36,    6'd37, 7'sd0},
        '{16'd71,    6'd63, 7'sd0},
        '{16'd0,     6'd10, 7'sd63},
        '{16'd0,     6'd10, 7'h40},
        '{16'd0,     6'd10, -7'sd63},
        '{16'd65535, 6'd2,  -7'sd63},
        '{16'd65535, 6'd2,  7'sd63},
        '{16'd1000,  6'd8,  -7'sd7}
    };
    string dir_text [N_DIRECTED] = '{
        "0", "FFFF", "1111111111111111", "1EKF", "Z", "9", "A", "12345",
        "    7", "00007", " 7", "42", " 42", "00FF", "101", "110", "10", "1Z",
        "", "", "", "", "", ""
    };

    // Clock
    always #2 i_clk = ~i_clk;

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(LONG_GAP_MIN, LONG_GAP_MAX);
        end
        return $urandom_range(1, 3);
    endfunction

    // Predict the characters of one number and queue them
    task automatic push_formatted_chars(input t_number_req req);
        int unsigned                 base;
        int unsigned                 mag;
        int unsigned                 rest;
        int unsigned                 d;
        int unsigned                 ndig;
        int unsigned                 npad;
        logic [rnf_pkg::PAD_W-1:0]   praw;
        logic [rnf_pkg::CHAR_W-1:0]  pad_ch;
        logic [rnf_pkg::CHAR_W-1:0]  digs [rnf_pkg::MAX_DIGITS];
        base = req.radix;
        if (base < int'(rnf_pkg::RADIX_MIN)) base = rnf_pkg::RADIX_MIN;
        if (base > int'(rnf_pkg::RADIX_MAX)) base = rnf_pkg::RADIX_MAX;
        praw = req.pad;
        // sign bit picks the pad character; magnitude saturates
        if (praw[rnf_pkg::PAD_W-1]) begin
            mag    = (1 << rnf_pkg::PAD_W) - praw;
            pad_ch = rnf_pkg::CH_ZERO;
        end else begin
            mag    = praw;
            pad_ch = rnf_pkg::CH_SPACE;
        end
        if (mag > rnf_pkg::PAD_MAX) mag = rnf_pkg::PAD_MAX;
        // digits, least significant first; zero still gives one digit
        rest = req.value;
        ndig = 0;
        do begin
            d          = rest % base;
            digs[ndig] = rnf_pkg::CHAR_W'(d < int'(rnf_pkg::TEN) ? int'(rnf_pkg::CH_ZERO) + d
                                          : int'(rnf_pkg::CH_A) + d - int'(rnf_pkg::TEN));
            ndig++;
            rest = rest / base;
        end while (rest > 0 && ndig < rnf_pkg::MAX_DIGITS);
        // padding runs to magnitude plus one
        npad = (mag >= ndig) ? mag - ndig + 1 : 0;
        repeat (npad) pending_chars.push_back({pad_ch, 1'b0});
        for (int k = ndig; k > 0; k--) begin
            pending_chars.push_back({digs[k-1], k == 1});
        end
    endtask

    // Offer one request and wait for it to be taken
    task automatic send_number(input t_number_req req, input string text);
        @(negedge i_clk);
        num_if.valid     = 1'b1;
        num_if.value     = req.value;
        num_if.radix     = req.radix;
        num_if.pad_width = req.pad;
        @(posedge i_clk);
        while (!num_if.ready) @(posedge i_clk);
        if (text.len() > 0) begin
            for (int k = 0; k < text.len(); k++) begin
                pending_chars.push_back({rnf_pkg::CHAR_W'(text[k]), k == text.len() - 1});
            end
        end else begin
            push_formatted_chars(req);
        end
    endtask

    // Sender idle with junk on the payload
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            num_if.valid     = 1'b0;
            num_if.value     = rnf_pkg::VALUE_W'($urandom);
            num_if.radix     = rnf_pkg::RADIX_W'($urandom);
            num_if.pad_width = rnf_pkg::PAD_W'($urandom);
        end
    endtask

    // Hold off until every owed character has come out
    task automatic wait_all_chars_out();
        @(negedge i_clk);
        num_if.valid = 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // Character sink: ready with random stalls, switched on and off in stretches
    always @(negedge i_clk) begin
        if ($urandom_range(0, 399) == 0) rx_stalls_on = !rx_stalls_on;
        if (rx_hold > 0) begin
            chr_if.ready = 1'b0;
            rx_hold--;
        end else begin
            chr_if.ready = 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
        end
    end

    // Watchdog and character check
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d characters owed", $realtime, pending_chars.size());
            $display("end of test: mismatches");
            $finish;
        end else if (i_rst_n && chr_if.valid && chr_if.ready) begin
            if (pending_chars.size() == 0) begin
                bad_chars++;
                $display("%0t: unexpected char: expected none, got %0d last %0b",
                         $realtime, chr_if.char_code, chr_if.last_char);
            end else begin
                head_char = pending_chars.pop_front();
                if (chr_if.char_code !== head_char.code) begin
                    bad_chars++;
                    $display("%0t: char_code: expected %0d '%c', got %0d '%c'", $realtime,
                             head_char.code, head_char.code, chr_if.char_code, chr_if.char_code);
                end
                if (chr_if.last_char !== head_char.last) begin
                    bad_chars++;
                    $display("%0t: last_char: expected %0b, got %0b",
                             $realtime, head_char.last, chr_if.last_char);
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_number_req req;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        num_if.valid     = 1'b0;
        num_if.value     = '0;
        num_if.radix     = '0;
        num_if.pad_width = '0;
        chr_if.ready     = 1'b0;
        bad_chars        = 0;
        cycle_count      = 0;
        rx_hold          = 0;
        rx_stalls_on     = 1'b1;
        tx_gaps_on       = 1'b1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_number(dir_reqs[i], dir_text[i]);
            if ($urandom_range(0, 1) == 0) idle_cycles(pick_gap());
        end
        wait_all_chars_out();

        // random numbers, biased toward edges and the common bases
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) tx_gaps_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 7))
                0: req.value = rnf_pkg::VALUE_W'($urandom_range(0, 15));
                1: req.value = rnf_pkg::VALUE_W'(16'hFFFF - $urandom_range(0, 15));
                2: req.value = rnf_pkg::VALUE_W'(1 << $urandom_range(0, rnf_pkg::VALUE_W - 1));
                default: req.value = rnf_pkg::VALUE_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: req.radix = rnf_pkg::RADIX_W'($urandom_range(0, 63));
                1: req.radix = rnf_pkg::RADIX_W'(2);
                2: req.radix = rnf_pkg::RADIX_W'(10);
                3: req.radix = rnf_pkg::RADIX_W'(16);
                4: req.radix = rnf_pkg::RADIX_W'(36);
                default: req.radix = rnf_pkg::RADIX_W'($urandom_range(2, 36));
            endcase
            case ($urandom_range(0, 5))
                0, 1: req.pad = '0;
                2: req.pad = rnf_pkg::PAD_W'($urandom_range(0, 16));
                3: req.pad = rnf_pkg::PAD_W'(128 - $urandom_range(1, 16));
                default: req.pad = rnf_pkg::PAD_W'($urandom_range(0, 127));
            endcase
            send_number(req, "");
            if (i % 60 == 59) begin
                wait_all_chars_out();
            end else if (tx_gaps_on && $urandom_range(0, 2) != 0) begin
                idle_cycles(pick_gap());
            end
        end

        // drain, then give stray characters a chance to show
        wait_all_chars_out();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_chars == 0 && pending_chars.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rnf_pkg.sv
rtl/core/rnf_in_if.sv
rtl/core/rnf_out_if.sv
rtl/core/rnf_ctrl.sv
rtl/core/rnf_dp.sv
rtl/core/radix_number_formatter_top.sv
test/radix_number_formatter_top_tb.sv
